// ===== src/pstbl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pstbl_pkg
// shared constants, codes and types for the per-source token bucket limiter
// ----------------------------------------------------------------------------
package pstbl_pkg;

  localparam int unsigned NumSlots  = 16;
  localparam int unsigned SlotW     = $clog2(NumSlots);
  localparam int unsigned CountW    = $clog2(NumSlots + 1);
  localparam int unsigned RefillClampMs = 1000;

  typedef enum logic [1:0] {
    MODE_ADMIT  = 2'd0,
    MODE_REFILL = 2'd1,
    MODE_EVICT  = 2'd2,
    MODE_STATS  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DROPPED   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_BURST = 2'd0,
    REG_RATE  = 2'd1,
    REG_EVICT = 2'd2
  } reg_idx_t;

  // one slot entry as held in the memory
  typedef struct packed {
    logic [15:0] level;
    logic [39:0] last_refill;
    logic [39:0] last_seen;
    logic [31:0] drops;
    logic [31:0] passes;
  } slot_t;

endpackage
`default_nettype wire

// ===== src/per_source_token_bucket_limiter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// per_source_token_bucket_limiter
// table of per-source token buckets: admit, refill all, evict idle, stats
// ----------------------------------------------------------------------------
// usage:
//   requests arrive on the s_axis group (tdata holds now_ms, source_id; tuser
//   holds mode). one result transfer leaves on m_axis for every request.
//   configuration is a plain write port (cfg_we, cfg_index, cfg_data), to be
//   used only while the block is idle; the block does not enforce this.
// sequencing:
//   one request at a time. admit and stats scan the source tags (held in
//   flip-flops with the valid bits) one slot a cycle over all 16 slots, then
//   decide. a hit then reads the entry from the registered-read memory
//   (S_READ) and modifies/writes it (S_ONE) before the result is valid.
//   a newly claimed slot needs no read and goes straight to S_ONE. table full
//   and not found answer straight from the decision. refill and evict stream
//   the 16 slots through the memory, each processed once its read data is
//   registered, with the next read already issued. the next request is taken
//   only after the result has left on m_axis.
// reset:
//   rst clears valid bits, the state and the configuration registers to their
//   defaults. memory entries are not cleared: a freed slot is rewritten when
//   it is claimed again, so no clearing pass is needed.
// stall:
//   a result waits in the output register until m_tready; no new request is
//   taken until it has gone.
// ----------------------------------------------------------------------------
module per_source_token_bucket_limiter (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [71:0]  s_tdata,   // source_id[31:0], now_ms[71:32]
  input  wire logic [1:0]   s_tuser,   // mode
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [87:0]       m_tdata,   // status, token_level, drop_total,
                                       // pass_total, active_sources, zeros
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  import pstbl_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_READ   = 6'b000100,
    S_ONE    = 6'b001000,
    S_SWEEP  = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t state;

  // configuration
  logic [15:0] burst_capacity;
  logic [15:0] refill_rate;
  logic [31:0] evict_after_ms;

  // slot tags and valid bits in flip-flops, bucket state in memory
  logic [NumSlots-1:0] slot_valid;
  logic [31:0]         slot_source [NumSlots];
  slot_t               mem [NumSlots];
  slot_t               rd_data;
  logic [SlotW-1:0]    rd_addr;
  logic                wr_en;
  logic [SlotW-1:0]    wr_addr;
  slot_t               wr_data;

  // request
  mode_t       mode;
  logic [31:0] src;
  logic [39:0] now;

  logic [SlotW:0]   idx;      // scan and sweep counter, one wider to reach the end
  logic [SlotW-1:0] hit_slot;
  logic             hit;
  logic [SlotW-1:0] free_slot;
  logic             free_found;
  logic             fresh;    // admit claimed a new slot
  logic [SlotW-1:0] rd_idx;   // slot whose read was issued last cycle
  logic             rd_ok;
  logic [SlotW-1:0] pr_idx;   // slot whose data is on rd_data
  logic             pr_ok;

  // result
  status_t     r_status;
  logic [15:0] r_level;
  logic [31:0] r_drops;
  logic [31:0] r_passes;
  logic [CountW-1:0] active;

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // active count and per-slot arithmetic
  logic [39:0] elapsed;
  logic [9:0]  elapsed_c;
  logic [25:0] credit;
  logic [26:0] sum;
  logic [39:0] idle;

  always_comb begin
    elapsed   = now - rd_data.last_refill;
    elapsed_c = (elapsed > 40'(RefillClampMs)) ? 10'(RefillClampMs) : elapsed[9:0];
    credit    = elapsed_c * refill_rate;
    sum       = {11'd0, rd_data.level} + {1'b0, credit};
    idle      = now - rd_data.last_seen;
  end

  always_comb begin
    active = '0;
    for (int i = 0; i < NumSlots; i++) begin
      active = active + CountW'(slot_valid[i]);
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {1'b0, active, r_passes, r_drops, r_level, r_status};

  always_ff @(posedge clk) begin
    wr_en  <= 1'b0;
    rd_ok  <= 1'b0;
    pr_ok  <= rd_ok;
    pr_idx <= rd_idx;
    if (rst) begin
      state          <= S_IDLE;
      slot_valid     <= '0;
      burst_capacity <= 16'd100;
      refill_rate    <= 16'd1;
      evict_after_ms <= 32'd60000;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BURST: burst_capacity <= cfg_data[15:0];
          REG_RATE:  refill_rate    <= cfg_data[15:0];
          REG_EVICT: evict_after_ms <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            mode       <= mode_t'(s_tuser);
            src        <= s_tdata[31:0];
            now        <= s_tdata[71:32];
            idx        <= '0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            fresh      <= 1'b0;
            r_status   <= ST_OK;
            r_level    <= '0;
            r_drops    <= '0;
            r_passes   <= '0;
            state      <= (mode_t'(s_tuser) == MODE_ADMIT ||
                           mode_t'(s_tuser) == MODE_STATS) ? S_SCAN : S_SWEEP;
          end
        end
        S_SCAN: begin
          // tag compare and lowest free slot, one slot a cycle
          if (idx[SlotW] == 1'b0) begin
            if (slot_valid[idx[SlotW-1:0]] && slot_source[idx[SlotW-1:0]] == src
                && !hit) begin
              hit      <= 1'b1;
              hit_slot <= idx[SlotW-1:0];
            end
            if (!slot_valid[idx[SlotW-1:0]] && !free_found) begin
              free_found <= 1'b1;
              free_slot  <= idx[SlotW-1:0];
            end
            idx <= idx + 1'b1;
          end else if (hit) begin
            rd_addr <= hit_slot;
            state   <= S_READ;
          end else if (mode == MODE_STATS) begin
            r_status <= ST_NOT_FOUND;
            state    <= S_OUT;
          end else if (!free_found) begin
            r_status <= ST_FULL;
            state    <= S_OUT;
          end else begin
            hit_slot                <= free_slot;
            fresh                   <= 1'b1;
            slot_valid[free_slot]   <= 1'b1;
            slot_source[free_slot]  <= src;
            state                   <= S_ONE;
          end
        end
        S_READ: begin
          state <= S_ONE;
        end
        S_ONE: begin
          // rd_data valid for hit_slot unless freshly claimed
          if (mode == MODE_STATS) begin
            r_level  <= rd_data.level;
            r_drops  <= rd_data.drops;
            r_passes <= rd_data.passes;
          end else begin
            slot_t e;
            e = fresh ? slot_t'{burst_capacity, now, now, 32'd0, 32'd0} : rd_data;
            e.last_seen = now;
            if (e.level == 16'd0) begin
              e.drops  = e.drops + 32'd1;
              r_status <= ST_DROPPED;
            end else begin
              e.level  = e.level - 16'd1;
              e.passes = e.passes + 32'd1;
            end
            r_level  <= e.level;
            r_drops  <= e.drops;
            r_passes <= e.passes;
            wr_en    <= 1'b1;
            wr_addr  <= hit_slot;
            wr_data  <= e;
          end
          state <= S_OUT;
        end
        S_SWEEP: begin
          // issue read idx; process the earlier read whose data is now on rd_data
          if (idx[SlotW] == 1'b0) begin
            rd_addr <= idx[SlotW-1:0];
            rd_idx  <= idx[SlotW-1:0];
            rd_ok   <= slot_valid[idx[SlotW-1:0]];
          end
          idx <= idx + 1'b1;
          if (pr_ok) begin
            wr_addr <= pr_idx;
            if (mode == MODE_REFILL) begin
              if (now > rd_data.last_refill) begin
                wr_en <= 1'b1;
                wr_data <= '{(sum > {11'd0, burst_capacity}) ? burst_capacity
                             : sum[15:0], now, rd_data.last_seen,
                             rd_data.drops, rd_data.passes};
              end
            end else if (now >= rd_data.last_seen && idle > {8'd0, evict_after_ms}) begin
              wr_en  <= 1'b1;
              wr_data <= '{burst_capacity, rd_data.last_refill, rd_data.last_seen,
                           32'd0, 32'd0};
              slot_valid[pr_idx] <= 1'b0;
            end
          end
          // last slot is processed on this edge
          if (idx == (SlotW + 1)'(NumSlots + 1)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== bench/bucket_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bucket_checker
// watches the request, result and register ports of the token bucket limiter,
// keeps its own copy of the slot table and compares every result transfer
// ----------------------------------------------------------------------------
module bucket_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [71:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [87:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending
);
  import pstbl_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [15:0] level;
    logic [31:0] drops;
    logic [31:0] passes;
    logic [4:0]  active;
  } verdict_t;

  logic        tbl_valid  [NumSlots];
  logic [31:0] tbl_source [NumSlots];
  logic [15:0] tbl_level  [NumSlots];
  logic [39:0] tbl_refill [NumSlots];
  logic [39:0] tbl_seen   [NumSlots];
  logic [31:0] tbl_drops  [NumSlots];
  logic [31:0] tbl_passes [NumSlots];

  logic [15:0] burst_cap;
  logic [15:0] rate;
  logic [31:0] idle_limit;

  verdict_t awaited_q[$];

  function automatic int lookup_source(logic [31:0] src);
    for (int i = 0; i < NumSlots; i++) begin
      if (tbl_valid[i] && tbl_source[i] == src) return i;
    end
    return -1;
  endfunction

  function automatic verdict_t work_out_request(mode_t mode, logic [31:0] src,
                                                logic [39:0] now);
    verdict_t    v;
    int          s;
    logic [39:0] elapsed;
    logic [31:0] sum;
    logic [4:0]  n;
    v = '0;
    v.status = ST_OK;
    case (mode)
      MODE_ADMIT: begin
        s = lookup_source(src);
        if (s < 0) begin
          for (int i = 0; i < NumSlots; i++) begin
            if (!tbl_valid[i]) begin
              s = i;
              break;
            end
          end
          if (s >= 0) begin
            tbl_valid[s]  = 1'b1;
            tbl_source[s] = src;
            tbl_level[s]  = burst_cap;
            tbl_refill[s] = now;
            tbl_drops[s]  = '0;
            tbl_passes[s] = '0;
          end
        end
        if (s < 0) begin
          v.status = ST_FULL;
        end else begin
          tbl_seen[s] = now;
          if (tbl_level[s] == 16'd0) begin
            tbl_drops[s] = tbl_drops[s] + 32'd1;
            v.status = ST_DROPPED;
          end else begin
            tbl_level[s]  = tbl_level[s] - 16'd1;
            tbl_passes[s] = tbl_passes[s] + 32'd1;
          end
          v.level  = tbl_level[s];
          v.drops  = tbl_drops[s];
          v.passes = tbl_passes[s];
        end
      end
      MODE_REFILL: begin
        for (int i = 0; i < NumSlots; i++) begin
          if (tbl_valid[i] && now > tbl_refill[i]) begin
            elapsed = now - tbl_refill[i];
            if (elapsed > 40'(RefillClampMs)) elapsed = 40'(RefillClampMs);
            sum = 32'(tbl_level[i]) + 32'(elapsed[9:0]) * 32'(rate);
            tbl_level[i]  = (sum > 32'(burst_cap)) ? burst_cap : sum[15:0];
            tbl_refill[i] = now;
          end
        end
      end
      MODE_EVICT: begin
        for (int i = 0; i < NumSlots; i++) begin
          if (tbl_valid[i] && now >= tbl_seen[i]
              && (now - tbl_seen[i]) > 40'(idle_limit)) begin
            tbl_valid[i]  = 1'b0;
            tbl_level[i]  = burst_cap;
            tbl_drops[i]  = '0;
            tbl_passes[i] = '0;
          end
        end
      end
      default: begin
        s = lookup_source(src);
        if (s < 0) begin
          v.status = ST_NOT_FOUND;
        end else begin
          v.level  = tbl_level[s];
          v.drops  = tbl_drops[s];
          v.passes = tbl_passes[s];
        end
      end
    endcase
    n = '0;
    for (int i = 0; i < NumSlots; i++) n += 5'(tbl_valid[i]);
    v.active = n;
    return v;
  endfunction

  assign pending = awaited_q.size();

  always @(posedge clk) begin
    verdict_t exp_v;
    verdict_t got;
    int       bad;
    bad = 0;
    if (rst) begin
      errors <= 0;
      burst_cap  = 16'd100;
      rate       = 16'd1;
      idle_limit = 32'd60000;
      for (int i = 0; i < NumSlots; i++) begin
        tbl_valid[i]  = 1'b0;
        tbl_source[i] = '0;
        tbl_level[i]  = 16'd100;
        tbl_refill[i] = '0;
        tbl_seen[i]   = '0;
        tbl_drops[i]  = '0;
        tbl_passes[i] = '0;
      end
      awaited_q.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_BURST: burst_cap  = cfg_data[15:0];
          REG_RATE:  rate       = cfg_data[15:0];
          REG_EVICT: idle_limit = cfg_data;
          default: ;
        endcase
      end
      // result side first: a request's own result cannot leave on its edge
      if (m_tvalid && m_tready) begin
        got.status = status_t'(m_tdata[1:0]);
        got.level  = m_tdata[17:2];
        got.drops  = m_tdata[49:18];
        got.passes = m_tdata[81:50];
        got.active = m_tdata[86:82];
        if (awaited_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual %h", $time, m_tdata);
          bad++;
        end else begin
          exp_v = awaited_q.pop_front();
          if (got.status !== exp_v.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_v.status,
                     got.status);
            bad++;
          end
          if (got.level !== exp_v.level) begin
            $display("%0t: token_level expected %0d actual %0d", $time, exp_v.level,
                     got.level);
            bad++;
          end
          if (got.drops !== exp_v.drops) begin
            $display("%0t: drop_total expected %0d actual %0d", $time, exp_v.drops,
                     got.drops);
            bad++;
          end
          if (got.passes !== exp_v.passes) begin
            $display("%0t: pass_total expected %0d actual %0d", $time, exp_v.passes,
                     got.passes);
            bad++;
          end
          if (got.active !== exp_v.active) begin
            $display("%0t: active_sources expected %0d actual %0d", $time,
                     exp_v.active, got.active);
            bad++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        awaited_q.push_back(work_out_request(mode_t'(s_tuser), s_tdata[31:0],
                                             s_tdata[71:32]));
      end
      errors <= errors + bad;
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives requests and register writes into the token bucket limiter under
// random back-pressure; a separate checker predicts and compares results
// ----------------------------------------------------------------------------
module tb;
  import pstbl_pkg::*;

  localparam int IdleLimit = 5000;   // cycles with no transfer before giving up

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;              // source_id[31:0], now_ms[71:32]
  logic [1:0]  s_tuser;              // mode
  logic        m_tvalid;
  logic        m_tready;
  logic [87:0] m_tdata;              // status, token_level, drop_total,
                                     // pass_total, active_sources, zero
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  int          errors;
  int          pending;

  // stimulus-side controls of the receiver, time base and id pool
  bit          long_hold;            // request one long hold-off
  bit          eager_sink;           // no new ready stalls started for a stretch
  logic [39:0] clock_ms;             // running time base for requests
  logic [31:0] id_pool[24];

  per_source_token_bucket_limiter u_top (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_index, .cfg_data
  );

  bucket_checker u_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_index, .cfg_data,
    .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: short random stalls, a few long ones, and clean stretches
  initial begin
    int stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        stall_left = 300;
      end else if (stall_left == 0 && !eager_sink) begin
        if ($urandom_range(0, 59) == 0) stall_left = $urandom_range(20, 80);
        else if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 4);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog: cycles in a row with no transfer on either side
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
      if (quiet >= IdleLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // one request transfer; the valid stays up into the next item when no gap
  task automatic send_request(mode_t mode, logic [31:0] src, logic [39:0] now);
    int gap;
    gap = 0;
    if ($urandom_range(0, 39) == 0) gap = $urandom_range(30, 80);
    else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {now, src};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);      // one request walk plus margin
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly well-formed traffic from a small id pool with time moving forward
  task automatic random_phase(int count);
    mode_t       mode;
    logic [31:0] src;
    int          pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) mode = MODE_ADMIT;
      else if (pick < 78) mode = MODE_REFILL;
      else if (pick < 88) mode = MODE_EVICT;
      else mode = MODE_STATS;
      pick = $urandom_range(0, 99);
      if (pick < 90) src = id_pool[$urandom_range(0, 23)];
      else src = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 70) clock_ms = clock_ms + $urandom_range(0, 40);
      else if (pick < 90) clock_ms = clock_ms + $urandom_range(500, 3000);
      else if (pick < 97) clock_ms = clock_ms + $urandom_range(50000, 200000);
      else clock_ms = clock_ms - $urandom_range(0, 100);   // time steps back
      if (k == count / 3) long_hold = 1'b1;
      eager_sink = (k % 100) < 15;
      send_request(mode, src, clock_ms);
    end
    eager_sink = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = MODE_ADMIT;
    cfg_we = 1'b0;
    cfg_index = REG_BURST;
    cfg_data = '0;
    long_hold = 1'b0;
    eager_sink = 1'b0;
    clock_ms = '0;
    id_pool[0] = 32'h0;
    id_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 24; i++) id_pool[i] = $urandom();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, every mode, full table, eviction, skipped refill
    send_request(MODE_STATS, 32'h1234_5678, 40'd0);          // not found
    send_request(MODE_ADMIT, 32'h0, 40'd0);
    send_request(MODE_ADMIT, 32'hFFFF_FFFF, 40'd0);
    send_request(MODE_STATS, 32'hFFFF_FFFF, 40'd0);
    send_request(MODE_REFILL, 32'h0, 40'd0);                 // no time elapsed
    send_request(MODE_REFILL, 32'h0, 40'd5);
    for (int i = 2; i < 17; i++)                             // last one is full
      send_request(MODE_ADMIT, id_pool[i], 40'd10);
    send_request(MODE_EVICT, 32'h0, 40'd60010);              // idle equal to limit
    send_request(MODE_EVICT, 32'h0, 40'hFF_FFFF_FFFF);       // all idle, freed
    send_request(MODE_ADMIT, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
    send_request(MODE_EVICT, 32'h0, 40'd3);                  // time went back
    drain_results();

    clock_ms = 40'd100;
    random_phase(150);
    // sender pause until every result is back
    drain_results();
    random_phase(50);
    drain_results();

    // wide buckets and fast refill; upper bits of the burst write dropped
    write_reg(REG_BURST, 32'hABCD_FFFF);
    write_reg(REG_RATE, 32'h0000_FFFF);
    write_reg(REG_EVICT, 32'd0);
    random_phase(120);
    drain_results();

    // single-token buckets, no refill, never evicted: drops pile up
    write_reg(REG_BURST, 32'd1);
    write_reg(REG_RATE, 32'd0);
    write_reg(REG_EVICT, 32'hFFFF_FFFF);
    random_phase(120);
    drain_results();

    // capacity zero: new slots start empty
    write_reg(REG_BURST, 32'd0);
    write_reg(REG_RATE, 32'd2);
    write_reg(REG_EVICT, 32'd800);
    random_phase(80);
    drain_results();

    // lowered capacity cuts older, fuller buckets at their next refill
    write_reg(REG_BURST, 32'd5);
    write_reg(REG_RATE, 32'd3);
    write_reg(REG_EVICT, 32'd5000);
    random_phase(110);
    drain_results();

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
